FILE: rtl/bclr_pkg.sv
`default_nettype none
package bclr_pkg;

  // Field widths
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned IDX_W   = 2;

  // Stream word widths (fields padded up to whole bytes)
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 16;

  // Register indexes on the config port
  localparam logic [IDX_W-1:0] REG_MULTI_WINDOW = 2'd0;
  localparam logic [IDX_W-1:0] REG_LONG_PRESS   = 2'd1;
  localparam logic [IDX_W-1:0] REG_REPEAT       = 2'd2;

  // Register reset values
  localparam logic [CFG_W-1:0] MULTI_WINDOW_RST = 16'd500;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST   = 16'd1000;
  localparam logic [CFG_W-1:0] REPEAT_RST       = 16'd200;

  // Button levels (active low)
  localparam logic LEVEL_PRESSED  = 1'b0;
  localparam logic LEVEL_RELEASED = 1'b1;

  typedef struct packed {
    logic [CFG_W-1:0] multi_window_ms;
    logic [CFG_W-1:0] long_press_ms;
    logic [CFG_W-1:0] repeat_ms;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic              button_level;
  } in_item_t;

  typedef struct packed {
    logic               repeating;
    logic               long_held;
    logic [COUNT_W-1:0] click_count;
    logic               level;
    logic               event_res;
  } out_item_t;

endpackage
`default_nettype wire

FILE: rtl/button_click_long_repeat_unit.sv
// A word accepted on s_axis reaches m_axis through the input register, then the result
//   register; the state update happens on the edge that loads the result.
// Throughput: one word per cycle; s_tready falls only while both registers hold words
//   and m_tready is low. Config writes never wait (cfg_ready is always high).
// Reset (rst, synchronous): both registers empty, button released, count and flags clear,
//   timers zero, config registers return to 500/1000/200 ms.
`default_nettype none
module button_click_long_repeat_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // s_tdata: [0] button_level, [32:1] now_ms, [39:33] zero
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [bclr_pkg::IN_DATA_W-1:0]  s_tdata,
  // m_tdata: [0] event_res, [1] level, [9:2] click_count, [10] long_held,
  //          [11] repeating, [15:12] zero
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [bclr_pkg::OUT_DATA_W-1:0]      m_tdata,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bclr_pkg::IDX_W-1:0]      cfg_index,
  input  wire logic [bclr_pkg::CFG_W-1:0]      cfg_data
);

  bclr_pkg::cfg_t      cfg;
  bclr_pkg::in_item_t  s_item;
  bclr_pkg::in_item_t  q_item;
  bclr_pkg::out_item_t r_item;
  logic                q_valid;
  logic                q_ready;

  // Unpack and pack stream words
  assign s_item  = s_tdata[$bits(bclr_pkg::in_item_t)-1:0];
  assign m_tdata = {{(bclr_pkg::OUT_DATA_W-$bits(bclr_pkg::out_item_t)){1'b0}}, r_item};

  assign cfg_ready = 1'b1;

  bclr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bclr_in_reg u_in (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_tvalid),
    .s_ready (s_tready),
    .s_item  (s_item),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item)
  );

  bclr_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item),
    .r_valid (m_tvalid),
    .r_ready (m_tready),
    .r_item  (r_item)
  );

endmodule
`default_nettype wire

FILE: rtl/bclr_cfg_regs.sv
`default_nettype none
module bclr_cfg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_valid,
  input  wire logic [bclr_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [bclr_pkg::CFG_W-1:0] cfg_data,
  output bclr_pkg::cfg_t                  cfg
);

  // Write one register per word; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.multi_window_ms <= bclr_pkg::MULTI_WINDOW_RST;
      cfg.long_press_ms   <= bclr_pkg::LONG_PRESS_RST;
      cfg.repeat_ms       <= bclr_pkg::REPEAT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bclr_pkg::REG_MULTI_WINDOW: cfg.multi_window_ms <= cfg_data;
        bclr_pkg::REG_LONG_PRESS:   cfg.long_press_ms   <= cfg_data;
        bclr_pkg::REG_REPEAT:       cfg.repeat_ms       <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bclr_in_reg.sv
`default_nettype none
module bclr_in_reg (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_valid,
  output logic                    s_ready,
  input  wire bclr_pkg::in_item_t s_item,
  output logic                    q_valid,
  input  wire logic               q_ready,
  output bclr_pkg::in_item_t      q_item
);

  // Take a new word whenever the held one leaves or the slot is empty
  assign s_ready = !q_valid || q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (s_ready) begin
      q_valid <= s_valid;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      q_item <= s_item;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bclr_core.sv
`default_nettype none
module bclr_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire bclr_pkg::cfg_t     cfg,
  input  wire logic               q_valid,
  output logic                    q_ready,
  input  wire bclr_pkg::in_item_t q_item,
  output logic                    r_valid,
  input  wire logic               r_ready,
  output bclr_pkg::out_item_t     r_item
);

  logic                               last_level;
  logic [bclr_pkg::TIME_W-1:0]        hold_start_time;
  logic [bclr_pkg::TIME_W-1:0]        group_start_time;
  logic [bclr_pkg::COUNT_W-1:0]       press_count;
  logic                               long_flag;
  logic                               repeat_flag;

  logic                               last_level_next;
  logic [bclr_pkg::TIME_W-1:0]        hold_start_time_next;
  logic [bclr_pkg::TIME_W-1:0]        group_start_time_next;
  logic [bclr_pkg::COUNT_W-1:0]       press_count_next;
  logic                               long_flag_next;
  logic                               repeat_flag_next;
  logic                               event_next;

  logic [bclr_pkg::TIME_W-1:0]        hold_elapsed;
  logic [bclr_pkg::TIME_W-1:0]        group_elapsed;
  logic [bclr_pkg::CFG_W-1:0]         hold_limit;
  logic                               hold_due;
  logic                               group_expired;
  logic                               advance;

  // Move an item through when the result slot is free or draining
  assign q_ready = !r_valid || r_ready;
  assign advance = q_valid && q_ready;

  // Wrapping elapsed times and the single hold threshold in use
  assign hold_elapsed  = q_item.now_ms - hold_start_time;
  assign group_elapsed = q_item.now_ms - group_start_time;
  assign hold_limit    = long_flag ? cfg.repeat_ms : cfg.long_press_ms;
  assign hold_due      = hold_elapsed > {{(bclr_pkg::TIME_W-bclr_pkg::CFG_W){1'b0}}, hold_limit};
  assign group_expired =
    group_elapsed > {{(bclr_pkg::TIME_W-bclr_pkg::CFG_W){1'b0}}, cfg.multi_window_ms};

  // Next state for the sample in the input register
  always_comb begin
    last_level_next       = last_level;
    hold_start_time_next  = hold_start_time;
    group_start_time_next = group_start_time;
    press_count_next      = press_count;
    long_flag_next        = long_flag;
    repeat_flag_next      = repeat_flag;
    event_next            = 1'b0;
    if (q_item.button_level != last_level) begin
      last_level_next = q_item.button_level;
      event_next      = 1'b1;
      if (q_item.button_level == bclr_pkg::LEVEL_PRESSED) begin
        hold_start_time_next = q_item.now_ms;
        if (group_expired) begin
          group_start_time_next = q_item.now_ms;
          press_count_next      = {{(bclr_pkg::COUNT_W-1){1'b0}}, 1'b1};
        end else begin
          press_count_next = press_count + 1'b1;
        end
      end else begin
        hold_start_time_next = '0;
        long_flag_next       = 1'b0;
        repeat_flag_next     = 1'b0;
      end
    end else if (q_item.button_level == bclr_pkg::LEVEL_PRESSED && hold_due) begin
      // Long press first, then repeats on the same timer
      hold_start_time_next = q_item.now_ms;
      event_next           = 1'b1;
      if (long_flag) begin
        repeat_flag_next = 1'b1;
      end else begin
        long_flag_next = 1'b1;
      end
    end
  end

  // Hold state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      last_level       <= bclr_pkg::LEVEL_RELEASED;
      hold_start_time  <= '0;
      group_start_time <= '0;
      press_count      <= '0;
      long_flag        <= 1'b0;
      repeat_flag      <= 1'b0;
      r_valid          <= 1'b0;
    end else begin
      if (advance) begin
        last_level       <= last_level_next;
        hold_start_time  <= hold_start_time_next;
        group_start_time <= group_start_time_next;
        press_count      <= press_count_next;
        long_flag        <= long_flag_next;
        repeat_flag      <= repeat_flag_next;
      end
      if (q_ready) begin
        r_valid <= q_valid;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (advance) begin
      r_item.event_res   <= event_next;
      r_item.level       <= last_level_next;
      r_item.click_count <= press_count_next;
      r_item.long_held   <= long_flag_next;
      r_item.repeating   <= repeat_flag_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bclr_checker.sv
`default_nettype none
module bclr_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            m_tvalid,
  input wire logic                            m_tready,
  input wire logic [bclr_pkg::OUT_DATA_W-1:0] m_tdata,
  input wire logic                            cfg_ready
);

  // A stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result word dropped while stalled");

  // Nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result word valid after reset");

  // A released button never reports long press or repeat
  a_release_clears: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1] |-> !m_tdata[10] && !m_tdata[11])
    else $error("flags set while released");

  // Repeat phase only follows a long press
  a_repeat_after_long: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[11] |-> m_tdata[10])
    else $error("repeat without long press");

  // Config writes never wait
  a_cfg_ready: assert property (@(posedge clk)
    cfg_ready)
    else $error("config port not ready");

endmodule

bind button_click_long_repeat_unit bclr_checker u_bclr_checker (.*);
`default_nettype wire

FILE: bench/button_click_long_repeat_unit_tb.sv
`default_nettype none
module button_click_long_repeat_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Index with no register behind it; writes to it must change nothing
  localparam logic [bclr_pkg::IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int unsigned STALL_LIMIT = 4000;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [bclr_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [bclr_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [bclr_pkg::IDX_W-1:0]      cfg_index = '0;
  logic [bclr_pkg::CFG_W-1:0]      cfg_data = '0;

  button_click_long_repeat_unit uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Register copy, reset values
  logic [bclr_pkg::CFG_W-1:0] win_ms  = bclr_pkg::MULTI_WINDOW_RST;
  logic [bclr_pkg::CFG_W-1:0] long_ms = bclr_pkg::LONG_PRESS_RST;
  logic [bclr_pkg::CFG_W-1:0] rep_ms  = bclr_pkg::REPEAT_RST;

  // Button tracker state
  logic                         btn_level   = bclr_pkg::LEVEL_RELEASED;
  logic [bclr_pkg::TIME_W-1:0]  hold_t      = '0;
  logic [bclr_pkg::TIME_W-1:0]  group_t     = '0;
  logic [bclr_pkg::COUNT_W-1:0] clicks      = '0;
  logic                         long_seen   = 1'b0;
  logic                         repeat_seen = 1'b0;

  bclr_pkg::in_item_t  sample_q[$];
  bclr_pkg::out_item_t status_q[$];

  logic [bclr_pkg::TIME_W-1:0] t_cur = '0;
  int unsigned n_queued = 0;
  int unsigned idle_pct = 11;
  int unsigned errors = 0;
  int unsigned n_checked = 0, n_events = 0, n_long = 0, n_repeat = 0, n_wraps = 0;
  int unsigned stall = 0;
  logic in_taken = 1'b0;
  logic cfg_taken = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  // Work out the status word that one pin sample produces
  function automatic bclr_pkg::out_item_t predict_sample(bclr_pkg::in_item_t w);
    bclr_pkg::out_item_t r;
    logic ev;
    ev = 1'b0;
    if (w.button_level != btn_level) begin
      btn_level = w.button_level;
      if (w.button_level == bclr_pkg::LEVEL_PRESSED) begin
        hold_t = w.now_ms;
        if (w.now_ms - group_t > {16'b0, win_ms}) begin
          clicks = '0;
          group_t = w.now_ms;
        end
        if (clicks == '1) n_wraps++;
        clicks = clicks + 1'b1;
      end else begin
        hold_t = '0;
        long_seen = 1'b0;
        repeat_seen = 1'b0;
      end
      ev = 1'b1;
    end else if (w.button_level == bclr_pkg::LEVEL_PRESSED) begin
      if (!long_seen) begin
        if (w.now_ms - hold_t > {16'b0, long_ms}) begin
          long_seen = 1'b1;
          hold_t = w.now_ms;
          ev = 1'b1;
          n_long++;
        end
      end else if (w.now_ms - hold_t > {16'b0, rep_ms}) begin
        repeat_seen = 1'b1;
        hold_t = w.now_ms;
        ev = 1'b1;
        n_repeat++;
      end
    end
    if (ev) n_events++;
    r.event_res   = ev;
    r.level       = btn_level;
    r.click_count = clicks;
    r.long_held   = long_seen;
    r.repeating   = repeat_seen;
    return r;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Track handshakes, predict on accepted samples, check status words
  always @(posedge clk) begin
    bclr_pkg::out_item_t got;
    bclr_pkg::out_item_t want;
    in_taken  <= !rst && s_tvalid && s_tready;
    cfg_taken <= !rst && cfg_valid && cfg_ready;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bclr_pkg::REG_MULTI_WINDOW: win_ms = cfg_data;
          bclr_pkg::REG_LONG_PRESS:   long_ms = cfg_data;
          bclr_pkg::REG_REPEAT:       rep_ms = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        status_q.push_back(predict_sample(
          bclr_pkg::in_item_t'(s_tdata[$bits(bclr_pkg::in_item_t)-1:0])));
      if (m_tvalid && m_tready) begin
        got = bclr_pkg::out_item_t'(m_tdata[$bits(bclr_pkg::out_item_t)-1:0]);
        if (status_q.size() == 0) begin
          $error("status word with no sample pending: %h", m_tdata);
          errors++;
        end else begin
          want = status_q.pop_front();
          n_checked++;
          check_field("event_res", 8'(want.event_res), 8'(got.event_res));
          check_field("level", 8'(want.level), 8'(got.level));
          check_field("click_count", want.click_count, got.click_count);
          check_field("long_held", 8'(want.long_held), 8'(got.long_held));
          check_field("repeating", 8'(want.repeating), 8'(got.repeating));
        end
      end
    end
  end

  // Present samples from the queue, idling at random
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (sample_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata <= {{(bclr_pkg::IN_DATA_W - $bits(bclr_pkg::in_item_t)){1'b0}},
                    sample_q.pop_front()};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Stall the status side at random
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= idle_pct);
  end

  // Give up when nothing moves for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      stall <= 0;
    else
      stall <= stall + 1;
    if (stall >= STALL_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic push_sample(logic lvl, logic [bclr_pkg::TIME_W-1:0] at);
    bclr_pkg::in_item_t w;
    w.button_level = lvl;
    w.now_ms = at;
    t_cur = at;
    sample_q.push_back(w);
    n_queued++;
  endtask

  task automatic write_reg(logic [bclr_pkg::IDX_W-1:0] idx, logic [bclr_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    while (!cfg_taken) @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hold until every sample is in and every status word is out
  task automatic drain();
    while (n_checked < n_queued) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Mostly press/hold/release sequences timed around the current settings
  task automatic random_run(int unsigned n);
    int unsigned target;
    int unsigned pick;
    int unsigned span;
    target = n_queued + n;
    span = long_ms / 3 + rep_ms + 2;
    while (n_queued < target) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        push_sample(bclr_pkg::LEVEL_PRESSED, t_cur + $urandom_range(0, win_ms + 2));
        repeat ($urandom_range(0, 10))
          push_sample(bclr_pkg::LEVEL_PRESSED, t_cur + $urandom_range(0, span));
        push_sample(bclr_pkg::LEVEL_RELEASED, t_cur + $urandom_range(0, span));
      end else if (pick < 88) begin
        push_sample(1'($urandom_range(1)), $urandom());
      end else begin
        push_sample(bclr_pkg::LEVEL_RELEASED, t_cur + $urandom_range(0, 50));
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Default settings: idle release, long press, repeats, click groups, time wrap
    push_sample(bclr_pkg::LEVEL_RELEASED, 32'd0);
    push_sample(bclr_pkg::LEVEL_PRESSED, 32'd200);
    push_sample(bclr_pkg::LEVEL_PRESSED, 32'd700);
    push_sample(bclr_pkg::LEVEL_PRESSED, 32'd1201);
    push_sample(bclr_pkg::LEVEL_PRESSED, 32'd1300);
    push_sample(bclr_pkg::LEVEL_PRESSED, 32'd1402);
    push_sample(bclr_pkg::LEVEL_PRESSED, 32'd1603);
    push_sample(bclr_pkg::LEVEL_RELEASED, 32'd1700);
    push_sample(bclr_pkg::LEVEL_RELEASED, 32'd1750);
    push_sample(bclr_pkg::LEVEL_PRESSED, 32'd1800);
    push_sample(bclr_pkg::LEVEL_RELEASED, 32'd1850);
    push_sample(bclr_pkg::LEVEL_PRESSED, 32'd1900);
    push_sample(bclr_pkg::LEVEL_RELEASED, 32'd1950);
    push_sample(bclr_pkg::LEVEL_PRESSED, 32'd2000);
    push_sample(bclr_pkg::LEVEL_RELEASED, 32'd2100);
    push_sample(bclr_pkg::LEVEL_PRESSED, 32'hFFFF_FF00);
    push_sample(bclr_pkg::LEVEL_PRESSED, 32'h0000_0300);
    push_sample(bclr_pkg::LEVEL_RELEASED, 32'hFFFF_FFFF);
    push_sample(bclr_pkg::LEVEL_PRESSED, 32'd0);
    push_sample(bclr_pkg::LEVEL_RELEASED, 32'd5);
    drain();

    // Zero intervals: any nonzero elapsed time triggers; spare index is ignored
    write_reg(bclr_pkg::REG_MULTI_WINDOW, 16'd0);
    write_reg(bclr_pkg::REG_LONG_PRESS, 16'd0);
    write_reg(bclr_pkg::REG_REPEAT, 16'd0);
    write_reg(REG_SPARE, 16'hFFFF);
    push_sample(bclr_pkg::LEVEL_PRESSED, 32'd10);
    push_sample(bclr_pkg::LEVEL_PRESSED, 32'd10);
    push_sample(bclr_pkg::LEVEL_PRESSED, 32'd11);
    push_sample(bclr_pkg::LEVEL_PRESSED, 32'd11);
    push_sample(bclr_pkg::LEVEL_PRESSED, 32'd12);
    push_sample(bclr_pkg::LEVEL_RELEASED, 32'd12);
    push_sample(bclr_pkg::LEVEL_PRESSED, 32'd12);
    push_sample(bclr_pkg::LEVEL_RELEASED, 32'd13);
    drain();

    // Widest window: drive the click counter through its wrap
    write_reg(bclr_pkg::REG_MULTI_WINDOW, 16'hFFFF);
    write_reg(bclr_pkg::REG_LONG_PRESS, 16'hFFFF);
    write_reg(bclr_pkg::REG_REPEAT, 16'hFFFF);
    repeat (260) begin
      push_sample(bclr_pkg::LEVEL_PRESSED, t_cur + $urandom_range(1, 3));
      push_sample(bclr_pkg::LEVEL_RELEASED, t_cur + $urandom_range(0, 3));
    end
    drain();

    // Random phases; the first runs with no idling on either side
    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 2) begin
        write_reg(bclr_pkg::REG_MULTI_WINDOW, 16'($urandom_range(0, 65535)));
        write_reg(bclr_pkg::REG_LONG_PRESS, 16'($urandom_range(0, 65535)));
        write_reg(bclr_pkg::REG_REPEAT, 16'($urandom_range(0, 65535)));
      end else begin
        write_reg(bclr_pkg::REG_MULTI_WINDOW, 16'($urandom_range(0, 600)));
        write_reg(bclr_pkg::REG_LONG_PRESS, 16'($urandom_range(0, 400)));
        write_reg(bclr_pkg::REG_REPEAT, 16'($urandom_range(0, 100)));
      end
      idle_pct = (ph == 0) ? 0 : 11;
      random_run(130);
      drain();
    end

    repeat (8) @(negedge clk);
    if (status_q.size() != 0) begin
      $error("%0d status words never arrived", status_q.size());
      errors++;
    end
    $display("checked %0d status words from %0d samples: %0d events", n_checked, n_queued,
             n_events);
    $display("%0d long presses, %0d repeats, %0d click counter wraps", n_long, n_repeat,
             n_wraps);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: files.f
rtl/bclr_pkg.sv
rtl/bclr_cfg_regs.sv
rtl/bclr_in_reg.sv
rtl/bclr_core.sv
rtl/button_click_long_repeat_unit.sv
rtl/bclr_checker.sv
bench/button_click_long_repeat_unit_tb.sv
